/* src/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// Box mean filter package
// Shared sizes, register indexes, beat types and the reciprocal table of the
// streaming box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

	// Sizing of the stores
	localparam int MAX_WINDOW     = 32;
	localparam int MAX_LINE_WIDTH = 4096;
	localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
	localparam int ROWSEL_W       = $clog2(MAX_WINDOW);
	localparam int LS_ADDR_W      = ROWSEL_W + COL_W;

	// Field and datapath widths
	localparam int PIXEL_W    = 8;
	localparam int MEAN_W     = 8;
	localparam int ROW_W      = 16;
	localparam int WIN_W      = 6;
	localparam int WIDTH_W    = 13;
	localparam int COLSUM_W   = 13;
	localparam int WSUM_W     = 18;
	localparam int RECIP_W    = 17;
	localparam int PROD_W     = WSUM_W + RECIP_W;
	localparam int MEAN_SHIFT = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd2;

	localparam logic [WIN_W-1:0]   RST_WINDOW_SIZE = 6'd1;
	localparam logic [WIDTH_W-1:0] RST_LINE_WIDTH  = 13'd640;
	localparam logic [ROW_W-1:0]   RST_LINE_COUNT  = 16'd480;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// Per-pixel control that travels down the pipeline
	typedef struct packed {
		logic             proc;
		logic             emit;
		logic             y_zero;
		logic             y_lt_w;
		logic             x_zero;
		logic             x_lt_w;
		logic             frame_last;
		logic [COL_W-1:0] out_x;
		logic [ROW_W-1:0] out_y;
	} pix_ctl_t;

	// One result beat
	typedef struct packed {
		logic [MEAN_W-1:0] mean;
		logic [COL_W-1:0]  out_x;
		logic [ROW_W-1:0]  out_y;
		logic              frame_last;
	} mean_beat_t;

	// floor(65536 / (W*W)) for W = 1 .. 32
	function automatic logic [RECIP_W-1:0] recip_lookup(input logic [WIN_W-1:0] w);
		logic [RECIP_W-1:0] r;
		case (w)
			6'd1:  r = 17'd65536;
			6'd2:  r = 17'd16384;
			6'd3:  r = 17'd7281;
			6'd4:  r = 17'd4096;
			6'd5:  r = 17'd2621;
			6'd6:  r = 17'd1820;
			6'd7:  r = 17'd1337;
			6'd8:  r = 17'd1024;
			6'd9:  r = 17'd809;
			6'd10: r = 17'd655;
			6'd11: r = 17'd541;
			6'd12: r = 17'd455;
			6'd13: r = 17'd387;
			6'd14: r = 17'd334;
			6'd15: r = 17'd291;
			6'd16: r = 17'd256;
			6'd17: r = 17'd226;
			6'd18: r = 17'd202;
			6'd19: r = 17'd181;
			6'd20: r = 17'd163;
			6'd21: r = 17'd148;
			6'd22: r = 17'd135;
			6'd23: r = 17'd123;
			6'd24: r = 17'd113;
			6'd25: r = 17'd104;
			6'd26: r = 17'd96;
			6'd27: r = 17'd89;
			6'd28: r = 17'd83;
			6'd29: r = 17'd77;
			6'd30: r = 17'd72;
			6'd31: r = 17'd68;
			6'd32: r = 17'd64;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* src/bmf_pix_if.sv */
// ----------------------------------------------------------------------------
// Pixel stream interface
// Valid/ready channel carrying one source pixel and its frame start flag.
// ----------------------------------------------------------------------------
interface bmf_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bmf_pkg::PIXEL_W-1:0]  pixel;
	logic                         frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink   (input valid, pixel, frame_start, output ready);
endinterface

/* src/bmf_mean_if.sv */
// ----------------------------------------------------------------------------
// Mean stream interface
// Valid/ready channel carrying one window mean and its coordinates.
// ----------------------------------------------------------------------------
interface bmf_mean_if;
	logic                        valid;
	logic                        ready;
	logic [bmf_pkg::MEAN_W-1:0]  mean;
	logic [bmf_pkg::COL_W-1:0]   out_x;
	logic [bmf_pkg::ROW_W-1:0]   out_y;
	logic                        frame_last;

	modport source (output valid, mean, out_x, out_y, frame_last, input ready);
	modport sink   (input valid, mean, out_x, out_y, frame_last, output ready);
endinterface

/* src/bmf_line_mem.sv */
// ----------------------------------------------------------------------------
// Line memory
// Pixels of the last rows, one write and one registered read per cycle.
// A read and a write to the same entry in one cycle return the old pixel.
// ----------------------------------------------------------------------------
module bmf_line_mem (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [bmf_pkg::LS_ADDR_W-1:0]   wr_addr,
	input  logic [bmf_pkg::PIXEL_W-1:0]     wr_data,
	input  logic                            rd_en,
	input  logic [bmf_pkg::LS_ADDR_W-1:0]   rd_addr,
	output logic [bmf_pkg::PIXEL_W-1:0]     rd_data
);

	localparam int DEPTH = bmf_pkg::MAX_WINDOW * bmf_pkg::MAX_LINE_WIDTH;

	logic [bmf_pkg::PIXEL_W-1:0] mem_q [DEPTH];
	logic [bmf_pkg::PIXEL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/bmf_colsum_ram.sv */
// ----------------------------------------------------------------------------
// Column sum memory
// One running sum per column. The read data is registered; a write landing on
// the address being read in the same cycle is passed straight to the read.
// ----------------------------------------------------------------------------
module bmf_colsum_ram (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [bmf_pkg::COL_W-1:0]      wr_addr,
	input  logic [bmf_pkg::COLSUM_W-1:0]   wr_data,
	input  logic                           rd_en,
	input  logic [bmf_pkg::COL_W-1:0]      rd_addr,
	output logic [bmf_pkg::COLSUM_W-1:0]   rd_data
);

	logic [bmf_pkg::COLSUM_W-1:0] mem_q [bmf_pkg::MAX_LINE_WIDTH];
	logic [bmf_pkg::COLSUM_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/bmf_window_acc.sv */
// ----------------------------------------------------------------------------
// Window accumulator
// Keeps the running window sum from the column sums of the current line and
// scales it by the reciprocal of the window area.
// ----------------------------------------------------------------------------
module bmf_window_acc (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bmf_pkg::pix_ctl_t              ctl_s2,
	input  logic [bmf_pkg::COLSUM_W-1:0]   cs_s2,
	input  logic [bmf_pkg::WIN_W-1:0]      eff_w,
	input  logic [bmf_pkg::ROWSEL_W-1:0]   w_m1,
	output logic                           push,
	output bmf_pkg::mean_beat_t            beat,
	output logic [1:0]                     busy
);

	// Column sums of the most recent pixels, newest first
	logic [bmf_pkg::COLSUM_W-1:0] rcs_q [bmf_pkg::MAX_WINDOW];
	logic [bmf_pkg::WSUM_W-1:0]   wsum_q;
	logic [bmf_pkg::WSUM_W-1:0]   wsum_next;
	logic [bmf_pkg::COLSUM_W-1:0] rold;
	logic [bmf_pkg::RECIP_W-1:0]  recip_q;

	bmf_pkg::pix_ctl_t            ctl_s3;
	bmf_pkg::pix_ctl_t            ctl_s4;
	logic [bmf_pkg::WSUM_W-1:0]   wsum_s3;
	logic [bmf_pkg::PROD_W-1:0]   prod_s4;

	assign rold = rcs_q[w_m1];

	always_comb begin
		if (ctl_s2.x_zero) begin
			wsum_next = bmf_pkg::WSUM_W'(cs_s2);
		end else if (ctl_s2.x_lt_w) begin
			wsum_next = wsum_q + bmf_pkg::WSUM_W'(cs_s2);
		end else begin
			wsum_next = wsum_q + bmf_pkg::WSUM_W'(cs_s2) - bmf_pkg::WSUM_W'(rold);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.proc) begin
			rcs_q[0] <= cs_s2;
			for (int i = 1; i < bmf_pkg::MAX_WINDOW; i++) begin
				rcs_q[i] <= rcs_q[i-1];
			end
		end
		recip_q <= bmf_pkg::recip_lookup(eff_w);
		wsum_s3 <= wsum_next;
		prod_s4 <= wsum_s3 * recip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			if (ctl_s2.proc) begin
				wsum_q <= wsum_next;
			end
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	assign push            = ctl_s4.emit;
	assign beat.mean       = prod_s4[bmf_pkg::MEAN_SHIFT +: bmf_pkg::MEAN_W];
	assign beat.out_x      = ctl_s4.out_x;
	assign beat.out_y      = ctl_s4.out_y;
	assign beat.frame_last = ctl_s4.frame_last;
	assign busy            = {1'b0, ctl_s3.emit} + {1'b0, ctl_s4.emit};

endmodule

/* src/bmf_out_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small register queue between the pipeline and the output channel.
// ----------------------------------------------------------------------------
module bmf_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  bmf_pkg::mean_beat_t               push_data,
	input  logic                              pop,
	output logic                              valid,
	output bmf_pkg::mean_beat_t               data,
	output logic [bmf_pkg::FIFO_CNT_W-1:0]    count
);

	bmf_pkg::mean_beat_t               mem_q [bmf_pkg::FIFO_DEPTH];
	logic [bmf_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [bmf_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [bmf_pkg::FIFO_CNT_W-1:0]    cnt_q;
	logic                              do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

/* src/box_mean_filter_stream_top.sv */
// ----------------------------------------------------------------------------
// Box mean filter, streaming top level
// Takes 8-bit pixels in raster order and gives the mean of every W x W window
// that lies wholly inside the image, at the window's top-left coordinate.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake      Beat contents
//   pix      in         valid/ready    pixel, frame_start
//   res      out        valid/ready    mean, out_x, out_y, frame_last
//   cfg      in         write enable   cfg_index, cfg_data
//
// One pixel is taken every clock cycle while the input is not stalled. A mean
// reaches the output queue through the memory read, the column sum, the
// window sum and the multiply stages. The input stalls only when the
// eight-entry result queue, counting means still in the pipeline, is full.
// Reset clears the coordinates and the window sum and sets the configuration
// to its defaults; the stores are not cleared and need no clearing pass.
//
module box_mean_filter_stream_top (
	input  logic                              clk,
	input  logic                              arst_n,
	bmf_pix_if.sink                           pix,
	bmf_mean_if.source                        res,
	input  logic                              cfg_write,
	input  logic [bmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int COL_W    = bmf_pkg::COL_W;
	localparam int ROW_W    = bmf_pkg::ROW_W;
	localparam int ROWSEL_W = bmf_pkg::ROWSEL_W;
	localparam int WIN_W    = bmf_pkg::WIN_W;
	localparam int WIDTH_W  = bmf_pkg::WIDTH_W;
	localparam int COLSUM_W = bmf_pkg::COLSUM_W;
	localparam int CNT_W    = bmf_pkg::FIFO_CNT_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [WIN_W-1:0]   window_size_q;
	logic [WIDTH_W-1:0] line_width_q;
	logic [ROW_W-1:0]   line_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= bmf_pkg::RST_WINDOW_SIZE;
			line_width_q  <= bmf_pkg::RST_LINE_WIDTH;
			line_count_q  <= bmf_pkg::RST_LINE_COUNT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bmf_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[WIN_W-1:0];
				bmf_pkg::REG_LINE_WIDTH:  line_width_q  <= cfg_data[WIDTH_W-1:0];
				bmf_pkg::REG_LINE_COUNT:  line_count_q  <= cfg_data[ROW_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Out-of-range settings are clamped into their usable range.
	logic [WIN_W-1:0]    eff_w;
	logic [WIDTH_W-1:0]  eff_wid;
	logic [ROW_W-1:0]    eff_hgt;
	logic [WIN_W-1:0]    w_m1;

	always_comb begin
		if (window_size_q == '0) begin
			eff_w = WIN_W'(1);
		end else if (window_size_q > WIN_W'(bmf_pkg::MAX_WINDOW)) begin
			eff_w = WIN_W'(bmf_pkg::MAX_WINDOW);
		end else begin
			eff_w = window_size_q;
		end
		if (line_width_q == '0) begin
			eff_wid = WIDTH_W'(1);
		end else if (line_width_q > WIDTH_W'(bmf_pkg::MAX_LINE_WIDTH)) begin
			eff_wid = WIDTH_W'(bmf_pkg::MAX_LINE_WIDTH);
		end else begin
			eff_wid = line_width_q;
		end
		eff_hgt = (line_count_q == '0) ? ROW_W'(1) : line_count_q;
	end

	assign w_m1 = eff_w - WIN_W'(1);

	// ------------------------------------------------------------------
	// Input stage: coordinates and control of the accepted pixel
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept;
	logic             in_ready;

	logic [COL_W-1:0]   c0;
	logic [ROW_W-1:0]   r0;
	logic               wrap;
	logic [COL_W-1:0]   x;
	logic [ROW_W-1:0]   y;
	logic               live;
	logic [COL_W:0]     x_p1;
	logic [ROW_W:0]     y_p1;
	logic               x_end;
	logic [ROW_W-1:0]   y_next;
	bmf_pkg::pix_ctl_t  ctl_s0;

	function automatic logic [ROW_W-1:0] sat_inc(input logic [ROW_W-1:0] v);
		return (v == '1) ? v : v + ROW_W'(1);
	endfunction

	assign accept = pix.valid && in_ready;

	always_comb begin
		// A frame start puts this pixel at the origin; a column past the
		// line end moves it to the start of the next line.
		c0   = pix.frame_start ? '0 : col_q;
		r0   = pix.frame_start ? '0 : row_q;
		wrap = ({1'b0, c0} >= eff_wid);
		x    = wrap ? '0 : c0;
		y    = wrap ? sat_inc(r0) : r0;
		live = (y < eff_hgt);

		x_p1   = {1'b0, x} + (COL_W+1)'(1);
		y_p1   = {1'b0, y} + (ROW_W+1)'(1);
		x_end  = (x_p1 >= eff_wid);
		y_next = sat_inc(y);

		ctl_s0.proc       = accept && live;
		ctl_s0.emit       = accept && live && (x_p1 >= (COL_W+1)'(eff_w))
		                    && (y_p1 >= (ROW_W+1)'(eff_w));
		ctl_s0.y_zero     = (y == '0);
		ctl_s0.y_lt_w     = (y < ROW_W'(eff_w));
		ctl_s0.x_zero     = (x == '0);
		ctl_s0.x_lt_w     = (x < COL_W'(eff_w));
		ctl_s0.frame_last = (x_p1 == eff_wid) && (y_p1 == {1'b0, eff_hgt});
		ctl_s0.out_x      = x - COL_W'(w_m1);
		ctl_s0.out_y      = y - ROW_W'(w_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!live) begin
				// Past the last line: only the position moves on.
				col_q <= x;
				row_q <= y;
			end else if (x_end) begin
				col_q <= '0;
				row_q <= y_next;
			end else begin
				col_q <= x_p1[COL_W-1:0];
				row_q <= y;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stores. The line memory holds MAX_WINDOW rows, indexed by the low
	// row bits; the row leaving the window is W rows back.
	// ------------------------------------------------------------------
	logic [bmf_pkg::LS_ADDR_W-1:0] ls_new_addr;
	logic [bmf_pkg::LS_ADDR_W-1:0] ls_old_addr;
	logic [ROWSEL_W-1:0]           old_row;
	logic [bmf_pkg::PIXEL_W-1:0]   old_pix_s1;
	logic [COLSUM_W-1:0]           colsum_s1;

	assign old_row     = y[ROWSEL_W-1:0] - eff_w[ROWSEL_W-1:0];
	assign ls_new_addr = {y[ROWSEL_W-1:0], x};
	assign ls_old_addr = {old_row, x};

	bmf_line_mem u_line_mem (
		.clk     (clk),
		.wr_en   (ctl_s0.proc),
		.wr_addr (ls_new_addr),
		.wr_data (pix.pixel),
		.rd_en   (ctl_s0.proc),
		.rd_addr (ls_old_addr),
		.rd_data (old_pix_s1)
	);

	// ------------------------------------------------------------------
	// Stage 1: column sum update. With a one-pixel line the next pixel
	// reads the same column while this one writes it; the RAM forwards.
	// ------------------------------------------------------------------
	bmf_pkg::pix_ctl_t            ctl_s1;
	logic [bmf_pkg::PIXEL_W-1:0]  pix_s1;
	logic [COL_W-1:0]             x_s1;
	logic [COLSUM_W-1:0]          cs;

	always_comb begin
		if (ctl_s1.y_zero) begin
			cs = COLSUM_W'(pix_s1);
		end else if (ctl_s1.y_lt_w) begin
			cs = colsum_s1 + COLSUM_W'(pix_s1);
		end else begin
			cs = colsum_s1 + COLSUM_W'(pix_s1) - COLSUM_W'(old_pix_s1);
		end
	end

	bmf_colsum_ram u_colsum_ram (
		.clk     (clk),
		.wr_en   (ctl_s1.proc),
		.wr_addr (x_s1),
		.wr_data (cs),
		.rd_en   (ctl_s0.proc),
		.rd_addr (x),
		.rd_data (colsum_s1)
	);

	// Stage 2 registers feeding the window accumulator
	bmf_pkg::pix_ctl_t    ctl_s2;
	logic [COLSUM_W-1:0]  cs_s2;

	always_ff @(posedge clk) begin
		pix_s1 <= pix.pixel;
		x_s1   <= x;
		cs_s2  <= cs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 4: window sum and scaling
	// ------------------------------------------------------------------
	logic                 push;
	bmf_pkg::mean_beat_t  push_beat;
	logic [1:0]           win_busy;

	bmf_window_acc u_window_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.cs_s2  (cs_s2),
		.eff_w  (eff_w),
		.w_m1   (w_m1[ROWSEL_W-1:0]),
		.push   (push),
		.beat   (push_beat),
		.busy   (win_busy)
	);

	// ------------------------------------------------------------------
	// Result queue and input flow control. A pixel is taken only while
	// the queue has room for every mean already in flight plus one.
	// ------------------------------------------------------------------
	logic                 fifo_valid;
	bmf_pkg::mean_beat_t  fifo_beat;
	logic [CNT_W-1:0]     fifo_count;
	logic [CNT_W:0]       committed;

	bmf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_beat),
		.pop       (res.ready),
		.valid     (fifo_valid),
		.data      (fifo_beat),
		.count     (fifo_count)
	);

	assign committed = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(win_busy)
	                   + (CNT_W+1)'(ctl_s1.emit) + (CNT_W+1)'(ctl_s2.emit);
	assign in_ready  = (committed < (CNT_W+1)'(bmf_pkg::FIFO_DEPTH));

	assign pix.ready      = in_ready;
	assign res.valid      = fifo_valid;
	assign res.mean       = fifo_beat.mean;
	assign res.out_x      = fifo_beat.out_x;
	assign res.out_y      = fifo_beat.out_y;
	assign res.frame_last = fifo_beat.frame_last;

endmodule

/* src/bmf_checker.sv */
// ----------------------------------------------------------------------------
// Box mean filter port checker
// Watches the top-level channels over time; attached to the top by bind.
// ----------------------------------------------------------------------------
module bmf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [bmf_pkg::MEAN_W-1:0]   mean,
	input logic [bmf_pkg::COL_W-1:0]    out_x,
	input logic [bmf_pkg::ROW_W-1:0]    out_y,
	input logic                         frame_last
);

	// A waiting result beat is neither withdrawn nor changed.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mean) && $stable(out_x)
			&& $stable(out_y) && $stable(frame_last))
		else $error("result beat changed while stalled");

	// The input only backs off while results are queued for the output.
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty result queue");

	// A fresh result follows a taken pixel through the pipeline and the result queue.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 5))
		else $error("result appeared without a pixel five cycles earlier");

endmodule

bind box_mean_filter_stream_top bmf_checker u_bmf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pix.valid),
	.in_ready   (pix.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.mean       (res.mean),
	.out_x      (res.out_x),
	.out_y      (res.out_y),
	.frame_last (res.frame_last)
);

/* bench/bmf_mean_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box mean filter checker
// Watches the pixel, mean and configuration ports of the box mean filter,
// predicts every mean from its own model of the line store and running sums,
// and compares each mean beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module bmf_mean_checker
	import bmf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	input  logic                  pix_ready,
	input  logic [PIXEL_W-1:0]    pixel,
	input  logic                  frame_start,
	input  logic                  res_valid,
	input  logic                  res_ready,
	input  logic [MEAN_W-1:0]     mean,
	input  logic [COL_W-1:0]      out_x,
	input  logic [ROW_W-1:0]      out_y,
	input  logic                  frame_last,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           pending,
	output int unsigned           fail_count
);

	localparam int STORE_DEPTH  = MAX_WINDOW * MAX_LINE_WIDTH;

	logic [WIN_W-1:0]    win_size;
	logic [WIDTH_W-1:0]  line_len;
	logic [ROW_W-1:0]    line_total;

	logic [PIXEL_W-1:0]  line_mem [STORE_DEPTH];
	logic [COLSUM_W-1:0] col_sum [MAX_LINE_WIDTH];
	logic [COLSUM_W-1:0] recent_sum [MAX_WINDOW];
	logic [WSUM_W-1:0]   win_sum;
	int unsigned         col;
	int unsigned         row;

	mean_beat_t          mean_q [$];
	int unsigned         errors = 0;

	function automatic void next_line();
		col = 0;
		if (row < 32'hFFFF)
			row++;
	endfunction

	// Advances the model by one pixel; returns 1 when the pixel completes a window.
	function automatic bit predict_mean(input logic [PIXEL_W-1:0] p, input logic fs,
			output mean_beat_t beat);
		int unsigned w;
		int unsigned wid;
		int unsigned hgt;
		int unsigned x;
		int unsigned y;
		logic [PIXEL_W-1:0]  old_pix;
		logic [COLSUM_W-1:0] cs;
		logic [COLSUM_W-1:0] rold;
		logic [RECIP_W-1:0]  recip;
		logic [PROD_W-1:0]   prod;
		bit                  got;

		w   = (win_size == 0) ? 1 : ((win_size > MAX_WINDOW) ? MAX_WINDOW : win_size);
		wid = (line_len == 0) ? 1 : ((line_len > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : line_len);
		hgt = (line_total == 0) ? 1 : line_total;
		beat = '0;
		got = 1'b0;

		if (fs) begin
			col = 0;
			row = 0;
		end
		if (col >= wid)
			next_line();
		// Pixels past the last line of the frame are dropped.
		if (row >= hgt)
			return 1'b0;

		x = col;
		y = row;
		old_pix = line_mem[((y + MAX_WINDOW - w) % MAX_WINDOW) * MAX_LINE_WIDTH + x];
		line_mem[(y % MAX_WINDOW) * MAX_LINE_WIDTH + x] = p;

		if (y == 0)
			cs = COLSUM_W'(p);
		else if (y < w)
			cs = col_sum[x] + COLSUM_W'(p);
		else
			cs = col_sum[x] + COLSUM_W'(p) - COLSUM_W'(old_pix);
		col_sum[x] = cs;

		rold = recent_sum[(x + MAX_WINDOW - w) % MAX_WINDOW];
		if (x == 0)
			win_sum = WSUM_W'(cs);
		else if (x < w)
			win_sum = win_sum + WSUM_W'(cs);
		else
			win_sum = win_sum + WSUM_W'(cs) - WSUM_W'(rold);
		recent_sum[x % MAX_WINDOW] = cs;

		if (x + 1 >= w && y + 1 >= w) begin
			recip = RECIP_W'(65536 / (w * w));
			prod = PROD_W'(win_sum) * PROD_W'(recip);
			beat.mean       = prod[MEAN_SHIFT +: MEAN_W];
			beat.out_x      = COL_W'(x + 1 - w);
			beat.out_y      = ROW_W'(y + 1 - w);
			beat.frame_last = (x + 1 == wid) && (y + 1 == hgt);
			got = 1'b1;
		end

		if (x + 1 >= wid)
			next_line();
		else
			col = x + 1;
		return got;
	endfunction

	function automatic void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		mean_beat_t beat;
		mean_beat_t want;

		if (!arst_n) begin
			win_size   = RST_WINDOW_SIZE;
			line_len   = RST_LINE_WIDTH;
			line_total = RST_LINE_COUNT;
			win_sum    = '0;
			col        = 0;
			row        = 0;
			mean_q.delete();
			pending    <= 0;
			fail_count <= errors;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_WINDOW_SIZE: win_size   = cfg_data[WIN_W-1:0];
					REG_LINE_WIDTH:  line_len   = cfg_data[WIDTH_W-1:0];
					REG_LINE_COUNT:  line_total = cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end

			// Outgoing beats are matched before the incoming pixel is modelled, so a
			// mean can never be paired with a prediction made at the same edge.
			if (res_valid && res_ready) begin
				if (mean_q.size() == 0) begin
					errors++;
					$display("%0t: mean beat with none expected, expected none, actual %0d at (%0d,%0d)",
						$time, mean, out_x, out_y);
				end else begin
					want = mean_q.pop_front();
					compare_field("mean", want.mean, mean);
					compare_field("out_x", want.out_x, out_x);
					compare_field("out_y", want.out_y, out_y);
					compare_field("frame_last", want.frame_last, frame_last);
				end
			end

			if (pix_valid && pix_ready) begin
				if (predict_mean(pixel, frame_start, beat))
					mean_q.push_back(beat);
			end

			pending    <= mean_q.size();
			fail_count <= errors;
		end
	end

endmodule

/* bench/tb_box_mean_filter_stream_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box mean filter stream testbench
// Drives pixel frames through the streaming box mean filter under a range of
// window, line width and line count settings and random flow control, and
// leaves the checking of every mean beat to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_box_mean_filter_stream_top;
	import bmf_pkg::*;

	// Flow control patterns. Each phase fixes how often the pixel sender idles
	// and how often the mean receiver stalls, in percent of cycles.
	typedef enum int {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	localparam int RANDOM_ITEMS  = 200;
	// Long enough for the eight-entry result queue to fill and stall the input.
	localparam int LONG_HOLD     = 120;
	// This leaves a comfortable margin beyond the pipeline depth so that a pixel
	// which makes no mean has finished before the settings change.
	localparam int SETTLE_CYCLES = 12;
	localparam int RUN_LIMIT_NS  = 1_500_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           pending;
	int unsigned           fail_count;

	// The sender idle rate is only read by the stimulus process itself; the
	// receiver stall rate and hold requests cross into the receiver process and
	// are therefore only ever changed with nonblocking assignments.
	int unsigned           src_idle_pct = 0;
	int unsigned           snk_stall_pct = 0;
	int unsigned           hold_requests = 0;

	bmf_pix_if  pix_ch ();
	bmf_mean_if res_ch ();

	always #1 clk = ~clk;

	box_mean_filter_stream_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bmf_mean_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_ch.valid),
		.pix_ready   (pix_ch.ready),
		.pixel       (pix_ch.pixel),
		.frame_start (pix_ch.frame_start),
		.res_valid   (res_ch.valid),
		.res_ready   (res_ch.ready),
		.mean        (res_ch.mean),
		.out_x       (res_ch.out_x),
		.out_y       (res_ch.out_y),
		.frame_last  (res_ch.frame_last),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	// Pixel values lean towards the two extremes so that the sums often reach
	// their largest and smallest values.
	function automatic logic [PIXEL_W-1:0] rand_pixel();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		return PIXEL_W'($urandom_range(255));
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct = 0;
				snk_stall_pct <= 0;
			end
			IDLE_SOURCE: begin
				src_idle_pct = 56;
				snk_stall_pct <= 0;
			end
			IDLE_SINK: begin
				src_idle_pct = 0;
				snk_stall_pct <= 56;
			end
			default: begin
				src_idle_pct = 15;
				snk_stall_pct <= 15;
			end
		endcase
	endtask

	// Offers one pixel beat, after a random number of idle cycles, and returns at
	// the edge where it is taken. The caller either offers the next beat at that
	// same edge or lowers valid, so valid is assigned at most once per step.
	task automatic send_pixel(input logic [PIXEL_W-1:0] p, input logic fs);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.pixel       <= p;
		pix_ch.frame_start <= fs;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
	endtask

	// Stops offering pixels until every predicted mean has come out, then lets
	// the pipeline settle so that the block is truly idle. The first edge lets
	// the checker count the pixel taken at the edge where this task starts.
	task automatic wait_for_results();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Settings only change while the block is idle, so the task drains first.
	// The three writes go out on consecutive edges with the strobe held high.
	task automatic set_config(input int unsigned win, input int unsigned wid,
			input int unsigned lines);
		wait_for_results();
		cfg_write <= 1'b1;
		cfg_index <= REG_WINDOW_SIZE;
		cfg_data  <= CFG_DATA_W'(win);
		@(posedge clk);
		cfg_index <= REG_LINE_WIDTH;
		cfg_data  <= CFG_DATA_W'(wid);
		@(posedge clk);
		cfg_index <= REG_LINE_COUNT;
		cfg_data  <= CFG_DATA_W'(lines);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Mean receiver. A hold request takes precedence over the random stalls and
	// keeps ready low until the hold countdown kept here runs out.
	initial begin : mean_sink
		int unsigned hold_left;
		int unsigned served;

		hold_left = 0;
		served = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (served != hold_requests) begin
				served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	initial begin : pixel_source
		int unsigned i;
		int unsigned r;
		int unsigned done_items;
		int unsigned w_raw;
		int unsigned wid_raw;
		int unsigned cnt_raw;
		int unsigned ew;
		int unsigned ewid;
		int unsigned ehgt;
		int unsigned frame_len;
		int unsigned kind;
		int unsigned phase;

		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = REG_WINDOW_SIZE;
		cfg_data           = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.pixel       = '0;
		pix_ch.frame_start = 1'b0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, without idling. A zero window, width and count all act
		// as one, so every frame is a single pixel and its own mean. Pixels
		// after the last line are dropped until the next frame start.
		set_idling(IDLE_NONE);
		set_config(0, 0, 0);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'h11, 1'b0);
		send_pixel(8'h00, 1'b1);

		// A 2 x 2 window over a 3 x 2 image gives two means, the second flagged as
		// the last of its frame; the pixel after it is dropped.
		set_config(2, 3, 2);
		send_pixel(8'hFF, 1'b1);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h00, 1'b0);
		send_pixel(8'hAA, 1'b0);

		// A window larger than the image never gives a mean.
		set_config(3, 2, 2);
		send_pixel(8'h55, 1'b1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h01, 1'b0);
		send_pixel(8'h80, 1'b0);

		// The line width is lowered part way along the first line: the column is
		// then past the new line end, so the next pixel begins the second line.
		set_config(2, 8, 3);
		send_pixel(8'h10, 1'b1);
		for (i = 1; i < 5; i++)
			send_pixel(rand_pixel(), 1'b0);
		set_config(2, 3, 3);
		for (i = 0; i < 3; i++)
			send_pixel(rand_pixel(), 1'b0);

		// Back pressure: the receiver holds off for a long stretch while a window
		// of one makes a mean for every pixel, so the result queue fills and the
		// input stalls. Afterwards the sender waits for every mean to come out.
		set_config(1, 16, 4);
		hold_requests <= hold_requests + 1;
		for (i = 0; i < 64; i++)
			send_pixel(rand_pixel(), (i == 0));
		wait_for_results();

		// A width beyond the largest line saturates to it; with the largest line
		// count this short partial frame stays on the first line.
		set_config(1, 8191, 16'hFFFF);
		for (i = 0; i < 40; i++)
			send_pixel(rand_pixel(), (i == 0));

		// A window size above the largest acts as the largest one, and over
		// all-white pixels it gives the largest window sum.
		set_idling(IDLE_BOTH);
		set_config(63, MAX_WINDOW, MAX_WINDOW);
		for (i = 0; i < MAX_WINDOW * MAX_WINDOW; i++)
			send_pixel(8'hFF, (i == 0));

		// Random part. Most frames are complete with random contents; a few are
		// cut short by the next frame start, and a few are followed by stray
		// pixels that must be dropped. The settings change between frames only.
		done_items = 0;
		ewid = 1;
		ehgt = 1;
		while (done_items < RANDOM_ITEMS) begin
			phase = (done_items * 4) / RANDOM_ITEMS;
			set_idling(idle_mode_t'(phase > 3 ? 3 : phase));

			if (done_items == 0 || $urandom_range(2) == 0) begin
				r = $urandom_range(99);
				if (r < 80)
					w_raw = $urandom_range(1, 4);
				else if (r < 92)
					w_raw = $urandom_range(5, 8);
				else if (r < 96)
					w_raw = 0;
				else
					w_raw = $urandom_range(33, 63);
				ew = (w_raw == 0) ? 1 : ((w_raw > MAX_WINDOW) ? MAX_WINDOW : w_raw);
				// Mostly images that the window fits, sometimes tiny ones.
				if (ew <= 8 && $urandom_range(99) < 85) begin
					wid_raw = $urandom_range(ew, ew + 8);
					cnt_raw = $urandom_range(ew, ew + 4);
				end else begin
					wid_raw = $urandom_range(0, 12);
					cnt_raw = $urandom_range(0, 8);
				end
				ewid = (wid_raw == 0) ? 1 : wid_raw;
				ehgt = (cnt_raw == 0) ? 1 : cnt_raw;
				set_config(w_raw, wid_raw, cnt_raw);
			end

			frame_len = ewid * ehgt;
			kind = $urandom_range(99);
			if (kind < 10)
				frame_len = $urandom_range(1, frame_len);
			for (i = 0; i < frame_len; i++)
				send_pixel(rand_pixel(), (i == 0));
			done_items += frame_len;
			if (kind >= 90) begin
				repeat ($urandom_range(1, 4))
					send_pixel(rand_pixel(), 1'b0);
			end
		end

		// All pixels are in: wait for the last means, let the pipeline run dry
		// so that any stray beat would still be caught, then give the verdict.
		wait_for_results();
		if (fail_count == 0)
			$display("tb_box_mean_filter_stream_top: done, clean");
		else
			$display("tb_box_mean_filter_stream_top: done, errors");
		$finish;
	end

	// Safety net against a hung handshake or means that never arrive.
	initial begin : run_limit
		#(RUN_LIMIT_NS);
		$display("tb_box_mean_filter_stream_top: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
src/bmf_pkg.sv
src/bmf_pix_if.sv
src/bmf_mean_if.sv
src/bmf_line_mem.sv
src/bmf_colsum_ram.sv
src/bmf_window_acc.sv
src/bmf_out_fifo.sv
src/box_mean_filter_stream_top.sv
src/bmf_checker.sv
bench/bmf_mean_checker.sv
bench/tb_box_mean_filter_stream_top.sv
